### src/gbn_pkg.sv
package gbn_pkg;

    // queue and window sizing
    localparam int QUEUE_DEPTH = 64;
    localparam int MAX_WINDOW  = 8;
    localparam int RESULT_CAP  = 8;
    localparam int WIN_CAP     = (MAX_WINDOW < RESULT_CAP) ? MAX_WINDOW : RESULT_CAP;

    localparam int QIDX_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OCNT_W = $clog2(RESULT_CAP + 1);
    localparam int WLIM_W = 4;

    localparam logic [WLIM_W-1:0] WINDOW_RESET = WLIM_W'(4);

    // event codes
    localparam logic [1:0] FUNC_SEND    = 2'd0;
    localparam logic [1:0] FUNC_ACK     = 2'd1;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] sequence_number;
        logic [9:0]  frame_len;
        logic [15:0] frame_tag;
    } t_in_word;

    typedef struct packed {
        logic [15:0] tx_tag;
        logic [31:0] tx_seq;
        logic [9:0]  tx_len;
        logic        send_rejected;
        logic        last_of_run;
    } t_out_word;

    // one queue entry
    typedef struct packed {
        logic [31:0] seq;
        logic [9:0]  len;
        logic [15:0] tag;
    } t_desc;

    // access request from the controller to the descriptor store
    typedef struct packed {
        logic              wr_en;
        logic [QIDX_W-1:0] wr_off;
        logic              rd_en;
        logic [OCNT_W-1:0] rd_off;
    } t_store_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_RELEASE,
        S_EMIT_RD,
        S_EMIT_WR,
        S_REJECT
    } t_state;

    // circular slot: head plus an offset below the depth
    function automatic logic [QIDX_W-1:0] slot(input logic [QIDX_W-1:0] head,
                                               input logic [QIDX_W-1:0] off);
        logic [QIDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (QIDX_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (QIDX_W + 1)'(QUEUE_DEPTH);
        end
        return sum[QIDX_W-1:0];
    endfunction

endpackage

### src/gbn_desc_store.sv
module gbn_desc_store
    import gbn_pkg::*;
(
    input  logic              i_clk,
    input  logic [QIDX_W-1:0] i_head,
    input  t_store_req        i_req,
    input  t_desc             i_wr_data,
    output t_desc             o_rd_data
);

    t_desc mem [QUEUE_DEPTH];
    t_desc r_rd_data;

    logic [QIDX_W-1:0] wr_addr;
    logic [QIDX_W-1:0] rd_addr;

    // offsets from the queue head to physical slots
    assign wr_addr = slot(i_head, i_req.wr_off);
    assign rd_addr = slot(i_head, QIDX_W'(i_req.rd_off));

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[wr_addr] <= i_wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/go_back_n_arq_sender.sv
// Go-back-N sender window.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one event word:
// send a new frame, acknowledgment, or timeout. Output channel (o_out_valid /
// i_out_ready / o_out_data) carries one word per transmitted frame or per
// rejected send; last_of_run marks the final word caused by an event.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes window_limit
// and is always ready; write it only while the block is idle.
// One event is handled at a time; o_in_ready is high in the idle state only.
// Descriptors live in a 64-entry memory with a registered read port, which
// delivers one descriptor per cycle while the receiver does not stall.
// Send: the descriptor is queued and, while the window has room, read back
// and emitted; a send into a full window is only queued, and a send into a
// full queue produces one rejected word.
// Acknowledgment: outstanding frames are searched from the oldest; a match
// releases frames up to it and refills the window from waiting frames; an
// unmatched one releases nothing. Timeout: outstanding frames are resent.
// When the receiver stalls, the output register holds its word and the
// sequencer waits; no word is dropped.
// Reset empties the queue, clears the window and sets window_limit to 4.
module go_back_n_arq_sender
    import gbn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [WLIM_W-1:0] i_cfg_data
);

    t_state            r_state, n_state;
    logic [QIDX_W-1:0] r_head, n_head;
    logic [QCNT_W-1:0] r_queued, n_queued;
    logic [OCNT_W-1:0] r_outstanding, n_outstanding;
    logic [WLIM_W-1:0] r_window;
    logic [31:0]       r_key, n_key;
    logic [OCNT_W-1:0] r_idx, n_idx;
    logic              r_cmp_valid, n_cmp_valid;
    logic [OCNT_W-1:0] r_cmp_idx, n_cmp_idx;
    logic [OCNT_W-1:0] r_rel, n_rel;
    logic [OCNT_W-1:0] r_emit_off, n_emit_off;
    logic [OCNT_W-1:0] r_emit_left, n_emit_left;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out, n_out;

    t_store_req        store_req;
    t_desc             wr_desc;
    t_desc             rd_desc;

    logic [OCNT_W-1:0] lim;
    logic              in_fire;
    logic              out_free;

    // release arithmetic
    logic [OCNT_W-1:0] rel_out;
    logic [QCNT_W-1:0] rel_queued;
    logic [OCNT_W-1:0] rel_room;
    logic [QCNT_W-1:0] rel_wait;
    logic [OCNT_W-1:0] rel_min;
    logic [OCNT_W-1:0] rel_emit;

    // effective window: zero acts as one, saturate at the cap
    always_comb begin
        if (r_window == '0) begin
            lim = OCNT_W'(1);
        end else if ({1'b0, r_window} > (WLIM_W + 1)'(WIN_CAP)) begin
            lim = OCNT_W'(WIN_CAP);
        end else begin
            lim = OCNT_W'(r_window);
        end
    end

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign rel_out    = r_outstanding - r_rel;
    assign rel_queued = r_queued - QCNT_W'(r_rel);
    assign rel_room   = (lim > rel_out) ? (lim - rel_out) : '0;
    assign rel_wait   = rel_queued - QCNT_W'(rel_out);
    assign rel_min    = (r_rel < rel_room) ? r_rel : rel_room;
    assign rel_emit   = (QCNT_W'(rel_min) > rel_wait) ? OCNT_W'(rel_wait) : rel_min;

    assign wr_desc.seq = i_in_data.sequence_number;
    assign wr_desc.len = i_in_data.frame_len;
    assign wr_desc.tag = i_in_data.frame_tag;

    gbn_desc_store u_store (
        .i_clk     (i_clk),
        .i_head    (r_head),
        .i_req     (store_req),
        .i_wr_data (wr_desc),
        .o_rd_data (rd_desc)
    );

    // sequencer: next state, memory requests, output loads
    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_queued      = r_queued;
        n_outstanding = r_outstanding;
        n_key         = r_key;
        n_idx         = r_idx;
        n_cmp_valid   = 1'b0;
        n_cmp_idx     = r_cmp_idx;
        n_rel         = r_rel;
        n_emit_off    = r_emit_off;
        n_emit_left   = r_emit_left;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out         = r_out;
        store_req     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_key = i_in_data.sequence_number;
                    unique case (i_in_data.func)
                        FUNC_SEND: begin
                            if (r_queued >= QCNT_W'(QUEUE_DEPTH)) begin
                                n_state = S_REJECT;
                            end else begin
                                store_req.wr_en  = 1'b1;
                                store_req.wr_off = QIDX_W'(r_queued);
                                n_queued         = r_queued + 1'b1;
                                if (r_outstanding < lim) begin
                                    n_emit_off    = r_outstanding;
                                    n_emit_left   = OCNT_W'(1);
                                    n_outstanding = r_outstanding + 1'b1;
                                    n_state       = S_EMIT_RD;
                                end
                            end
                        end
                        FUNC_ACK: begin
                            if (r_outstanding != '0) begin
                                n_idx   = '0;
                                n_state = S_SEARCH;
                            end
                        end
                        FUNC_TIMEOUT: begin
                            if (r_outstanding != '0) begin
                                n_emit_off  = '0;
                                n_emit_left = r_outstanding;
                                n_state     = S_EMIT_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SEARCH: begin
                // issue one read per cycle, compare it in the following cycle
                if (r_idx < r_outstanding) begin
                    store_req.rd_en  = 1'b1;
                    store_req.rd_off = r_idx;
                    n_idx            = r_idx + 1'b1;
                    n_cmp_valid      = 1'b1;
                    n_cmp_idx        = r_idx;
                end
                if (r_cmp_valid) begin
                    if (rd_desc.seq == r_key) begin
                        n_rel       = r_cmp_idx + 1'b1;
                        n_cmp_valid = 1'b0;
                        n_state     = S_RELEASE;
                    end else if (r_cmp_idx + 1'b1 == r_outstanding) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_RELEASE: begin
                n_head   = slot(r_head, QIDX_W'(r_rel));
                n_queued = rel_queued;
                if (rel_emit != '0) begin
                    n_emit_off    = rel_out;
                    n_emit_left   = rel_emit;
                    n_outstanding = rel_out + rel_emit;
                    n_state       = S_EMIT_RD;
                end else begin
                    n_outstanding = rel_out;
                    n_state       = S_IDLE;
                end
            end

            S_EMIT_RD: begin
                store_req.rd_en  = 1'b1;
                store_req.rd_off = r_emit_off;
                n_emit_off       = r_emit_off + 1'b1;
                n_state          = S_EMIT_WR;
            end

            S_EMIT_WR: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.tx_tag        = rd_desc.tag;
                    n_out.tx_seq        = rd_desc.seq;
                    n_out.tx_len        = rd_desc.len;
                    n_out.send_rejected = 1'b0;
                    n_out.last_of_run   = (r_emit_left == OCNT_W'(1));
                    n_emit_left         = r_emit_left - 1'b1;
                    if (r_emit_left > OCNT_W'(1)) begin
                        store_req.rd_en  = 1'b1;
                        store_req.rd_off = r_emit_off;
                        n_emit_off       = r_emit_off + 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_REJECT: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.tx_tag        = '0;
                    n_out.tx_seq        = '0;
                    n_out.tx_len        = '0;
                    n_out.send_rejected = 1'b1;
                    n_out.last_of_run   = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_head        <= '0;
            r_queued      <= '0;
            r_outstanding <= '0;
            r_window      <= WINDOW_RESET;
            r_idx         <= '0;
            r_cmp_valid   <= 1'b0;
            r_emit_left   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_head        <= n_head;
            r_queued      <= n_queued;
            r_outstanding <= n_outstanding;
            r_idx         <= n_idx;
            r_cmp_valid   <= n_cmp_valid;
            r_emit_left   <= n_emit_left;
            r_out_valid   <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_window <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_cmp_idx  <= n_cmp_idx;
        r_rel      <= n_rel;
        r_emit_off <= n_emit_off;
        r_out      <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // outstanding frames are always a prefix of the queue
    a_out_le_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QCNT_W'(r_outstanding) <= r_queued)
        else $error("outstanding count above queued count");

    // window never grows past the cap
    a_out_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= OCNT_W'(WIN_CAP))
        else $error("outstanding count above window cap");

    // queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_queued <= QCNT_W'(QUEUE_DEPTH))
        else $error("queued count above depth");

    // emission always has work left
    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_RD || r_state == S_EMIT_WR) |-> (r_emit_left != '0))
        else $error("emission with nothing left");

    // a release always frees at least one frame that was outstanding
    a_release_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RELEASE) |-> (r_rel != '0 && r_rel <= r_outstanding))
        else $error("release count out of range");
`endif

endmodule
